// ===== design/p2w_pkg.sv =====
package p2w_pkg;

	localparam int NLANE     = 9;
	localparam int DIV_STEPS = 31;
	localparam int QW        = 31;
	localparam int REM_W     = 33;
	localparam int N2_W      = 33;
	localparam int CAM_W     = 47;
	localparam int BODY_W    = 48;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_INV_FX = 3'd0;
	localparam logic [IDX_W-1:0] REG_INV_FY = 3'd1;
	localparam logic [IDX_W-1:0] REG_CX     = 3'd2;
	localparam logic [IDX_W-1:0] REG_CY     = 3'd3;
	localparam logic [IDX_W-1:0] REG_AXIS   = 3'd4;
	localparam logic [IDX_W-1:0] REG_OFF_X  = 3'd5;
	localparam logic [IDX_W-1:0] REG_OFF_Y  = 3'd6;
	localparam logic [IDX_W-1:0] REG_OFF_Z  = 3'd7;

	localparam logic [1:0] AX_PLUS  = 2'd1;
	localparam logic [1:0] AX_MINUS = 2'd3;

	localparam logic [23:0] RST_INV_FOCAL = 24'd40406;
	localparam logic [15:0] RST_CENTER_X  = 16'd6792;
	localparam logic [15:0] RST_CENTER_Y  = 16'd3848;
	localparam logic [17:0] RST_AXIS_MAP  = 18'd49360;

	typedef struct packed {
		logic [23:0]      inv_fx;
		logic [23:0]      inv_fy;
		logic [15:0]      cx;
		logic [15:0]      cy;
		logic [17:0]      axis;
		logic [2:0][31:0] off;
	} cfg_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QW-1:0]    dlo;
		logic [QW-1:0]    quo;
	} div_lane_t;

	typedef struct packed {
		logic [2:0][BODY_W-1:0] body;
		logic [2:0][31:0]       veh;
		logic [N2_W-1:0]        n2;
		logic [NLANE-1:0]       neg;
		logic                   bad;
	} side_t;

	typedef struct packed {
		logic [2:0][31:0] world;
		logic             clipped;
		logic             bad;
	} res_t;

endpackage

// ===== design/p2w_if.sv =====
interface p2w_in_if;
	logic               valid;
	logic               ready;
	logic [15:0]        pixel_u;
	logic [15:0]        pixel_v;
	logic [31:0]        range_dist;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [31:0] vehicle_x;
	logic signed [31:0] vehicle_y;
	logic signed [31:0] vehicle_z;

	modport source (output valid, pixel_u, pixel_v, range_dist, quat_w, quat_x, quat_y,
		quat_z, vehicle_x, vehicle_y, vehicle_z, input ready);
	modport sink (input valid, pixel_u, pixel_v, range_dist, quat_w, quat_x, quat_y,
		quat_z, vehicle_x, vehicle_y, vehicle_z, output ready);
endinterface

interface p2w_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [31:0] world_z;
	logic               clipped;
	logic               bad_attitude;

	modport source (output valid, world_x, world_y, world_z, clipped, bad_attitude,
		input ready);
	modport sink (input valid, world_x, world_y, world_z, clipped, bad_attitude,
		output ready);
endinterface

interface p2w_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pixel_to_world_projection.sv =====
// channel  dir  words                                           handshake
// pix      in   pixel, range, attitude quaternion, position     valid/ready
// res      out  world x/y/z, clipped, bad_attitude              valid/ready
// cfg      in   register index, write data                      valid/ready (ready tied high)
//
// One word accepted per cycle while pix.ready is high; stages in order: 4 front
// stages, 31 divider stages (one quotient bit each, nine lanes), 4 back stages, output register.
// Reset clears all valid bits and loads register defaults; datapath is not reset.
// The pipeline advances as a whole; a one-word skid behind the output register
// absorbs a stall, and pix.ready drops only while that skid is occupied.
module pixel_to_world_projection #(
	parameter int FRAC_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	p2w_in_if.sink    pix,
	p2w_out_if.source res,
	p2w_cfg_if.sink   cfg
);
	import p2w_pkg::*;

	localparam logic [31:0] RST_MOUNT_Z = 32'(((2 << FRAC_BITS) + 50) / 100);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_fx <= RST_INV_FOCAL;
			cfg_q.inv_fy <= RST_INV_FOCAL;
			cfg_q.cx     <= RST_CENTER_X;
			cfg_q.cy     <= RST_CENTER_Y;
			cfg_q.axis   <= RST_AXIS_MAP;
			cfg_q.off[0] <= '0;
			cfg_q.off[1] <= '0;
			cfg_q.off[2] <= RST_MOUNT_Z;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_INV_FX: cfg_q.inv_fx <= cfg.data[23:0];
				REG_INV_FY: cfg_q.inv_fy <= cfg.data[23:0];
				REG_CX:     cfg_q.cx     <= cfg.data[15:0];
				REG_CY:     cfg_q.cy     <= cfg.data[15:0];
				REG_AXIS:   cfg_q.axis   <= cfg.data[17:0];
				REG_OFF_X:  cfg_q.off[0] <= cfg.data;
				REG_OFF_Y:  cfg_q.off[1] <= cfg.data;
				REG_OFF_Z:  cfg_q.off[2] <= cfg.data;
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	logic                  en;
	logic                  out_v_q, skid_v_q;
	res_t                  out_q, skid_q;
	logic                  front_v, div_v, back_v;
	div_lane_t [NLANE-1:0] lanes;
	side_t                 front_side, div_side;
	logic [NLANE-1:0][QW-1:0] quo;
	res_t                  back_res;
	logic [2:0][31:0]      veh;

	assign en        = !skid_v_q;
	assign pix.ready = en;
	assign veh       = {pix.vehicle_z, pix.vehicle_y, pix.vehicle_x};

	p2w_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_v       (pix.valid),
		.cfg        (cfg_q),
		.pixel_u    (pix.pixel_u),
		.pixel_v    (pix.pixel_v),
		.range_dist (pix.range_dist),
		.quat_w     (pix.quat_w),
		.quat_x     (pix.quat_x),
		.quat_y     (pix.quat_y),
		.quat_z     (pix.quat_z),
		.veh        (veh),
		.out_v      (front_v),
		.lanes      (lanes),
		.side       (front_side)
	);

	p2w_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (front_v),
		.lanes_in (lanes),
		.side_in  (front_side),
		.out_v    (div_v),
		.quo      (quo),
		.side_out (div_side)
	);

	p2w_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (div_v),
		.quo    (quo),
		.side   (div_side),
		.out_v  (back_v),
		.res    (back_res)
	);

	// output register with one-word skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (back_v)
				out_v_q <= 1'b1;
			else if (res.ready)
				out_v_q <= 1'b0;
			skid_v_q <= back_v && out_v_q && !res.ready;
		end else if (res.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && back_v && (!out_v_q || res.ready))
			out_q <= back_res;
		else if (!en && res.ready)
			out_q <= skid_q;
		if (en && back_v && out_v_q && !res.ready)
			skid_q <= back_res;
	end

	assign res.valid        = out_v_q;
	assign res.world_x      = out_q.world[0];
	assign res.world_y      = out_q.world[1];
	assign res.world_z      = out_q.world[2];
	assign res.clipped      = out_q.clipped;
	assign res.bad_attitude = out_q.bad;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a word while output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !res.ready) |=> (skid_v_q && $stable(skid_q)))
		else $error("skid word lost or changed under stall");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_v_q && out_v_q && !res.ready && back_v) |=> skid_v_q)
		else $error("pipeline word dropped under output stall");

endmodule

// ===== design/p2w_front.sv =====
module p2w_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_v,
	input  p2w_pkg::cfg_t                         cfg,
	input  logic [15:0]                           pixel_u,
	input  logic [15:0]                           pixel_v,
	input  logic [31:0]                           range_dist,
	input  logic signed [15:0]                    quat_w,
	input  logic signed [15:0]                    quat_x,
	input  logic signed [15:0]                    quat_y,
	input  logic signed [15:0]                    quat_z,
	input  logic [2:0][31:0]                      veh,
	output logic                                  out_v,
	output p2w_pkg::div_lane_t [p2w_pkg::NLANE-1:0] lanes,
	output p2w_pkg::side_t                        side
);
	import p2w_pkg::*;

	// s1: pixel offset times reciprocal focal, quaternion products
	logic signed [16:0] du_c, dv_c;
	logic signed [41:0] sx_c, sy_c;
	logic signed [41:0] sx_s1, sy_s1;
	logic signed [31:0] pww_s1, pxx_s1, pyy_s1, pzz_s1;
	logic signed [31:0] pxy_s1, pwz_s1, pxz_s1, pwy_s1, pyz_s1, pwx_s1;
	logic [31:0]        range_s1;
	logic [2:0][31:0]   veh_s1;
	logic               v_s1;

	always_comb begin
		du_c = $signed({1'b0, pixel_u}) - $signed({1'b0, cfg.cx});
		dv_c = $signed({1'b0, pixel_v}) - $signed({1'b0, cfg.cy});
		sx_c = du_c * $signed({1'b0, cfg.inv_fx});
		sy_c = dv_c * $signed({1'b0, cfg.inv_fy});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1    <= sx_c;
			sy_s1    <= sy_c;
			pww_s1   <= quat_w * quat_w;
			pxx_s1   <= quat_x * quat_x;
			pyy_s1   <= quat_y * quat_y;
			pzz_s1   <= quat_z * quat_z;
			pxy_s1   <= quat_x * quat_y;
			pwz_s1   <= quat_w * quat_z;
			pxz_s1   <= quat_x * quat_z;
			pwy_s1   <= quat_w * quat_y;
			pyz_s1   <= quat_y * quat_z;
			pwx_s1   <= quat_w * quat_x;
			range_s1 <= range_dist;
			veh_s1   <= veh;
		end
	end

	// s2: split ray scaling, quaternion sums
	logic [40:0]               mx_c, my_c;
	logic [52:0]               axx_s2, axy_s2;
	logic [51:0]               bxx_s2, bxy_s2;
	logic                      negx_s2, negy_s2;
	logic [N2_W-1:0]           n2_s2;
	logic signed [33:0]        num_c [NLANE];
	logic signed [33:0]        num_s2 [NLANE];
	logic [31:0]               range_s2;
	logic [2:0][31:0]          veh_s2;
	logic                      v_s2;

	always_comb begin
		mx_c = sx_s1[41] ? 41'(-sx_s1) : sx_s1[40:0];
		my_c = sy_s1[41] ? 41'(-sy_s1) : sy_s1[40:0];
		num_c[0] = 34'(pww_s1) + 34'(pxx_s1) - 34'(pyy_s1) - 34'(pzz_s1);
		num_c[1] = (34'(pxy_s1) - 34'(pwz_s1)) <<< 1;
		num_c[2] = (34'(pxz_s1) + 34'(pwy_s1)) <<< 1;
		num_c[3] = (34'(pxy_s1) + 34'(pwz_s1)) <<< 1;
		num_c[4] = 34'(pww_s1) - 34'(pxx_s1) + 34'(pyy_s1) - 34'(pzz_s1);
		num_c[5] = (34'(pyz_s1) - 34'(pwx_s1)) <<< 1;
		num_c[6] = (34'(pxz_s1) - 34'(pwy_s1)) <<< 1;
		num_c[7] = (34'(pyz_s1) + 34'(pwx_s1)) <<< 1;
		num_c[8] = 34'(pww_s1) - 34'(pxx_s1) - 34'(pyy_s1) + 34'(pzz_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axx_s2   <= 53'(mx_c[40:20]) * 53'(range_s1);
			bxx_s2   <= 52'(mx_c[19:0]) * 52'(range_s1);
			axy_s2   <= 53'(my_c[40:20]) * 53'(range_s1);
			bxy_s2   <= 52'(my_c[19:0]) * 52'(range_s1);
			negx_s2  <= sx_s1[41];
			negy_s2  <= sy_s1[41];
			n2_s2    <= N2_W'(pww_s1[30:0]) + N2_W'(pxx_s1[30:0]) +
				N2_W'(pyy_s1[30:0]) + N2_W'(pzz_s1[30:0]);
			for (int k = 0; k < NLANE; k++)
				num_s2[k] <= num_c[k];
			range_s2 <= range_s1;
			veh_s2   <= veh_s1;
		end
	end

	// s3: ray rounding, dividend setup
	logic [52:0]              lox_c, loy_c;
	logic [45:0]              qx_c, qy_c;
	logic signed [CAM_W-1:0]  camx_s3, camy_s3;
	logic [31:0]              range_s3;
	logic [2:0][31:0]         veh_s3;
	logic [N2_W-1:0]          n2_s3;
	logic [NLANE-1:0]         neg_s3;
	logic                     bad_s3;
	div_lane_t [NLANE-1:0]    lane_c, lane_s3;
	logic [32:0]              nmag_c [NLANE];
	logic [62:0]              dvd_c [NLANE];
	logic                     v_s3;

	always_comb begin
		lox_c = 53'({axx_s2[7:0], 20'd0}) + 53'(bxx_s2) + (53'd1 << 27);
		loy_c = 53'({axy_s2[7:0], 20'd0}) + 53'(bxy_s2) + (53'd1 << 27);
		qx_c  = 46'(axx_s2[52:8]) + 46'(lox_c[52:28]);
		qy_c  = 46'(axy_s2[52:8]) + 46'(loy_c[52:28]);
		for (int k = 0; k < NLANE; k++) begin
			nmag_c[k]     = num_s2[k][33] ? 33'(-num_s2[k]) : num_s2[k][32:0];
			dvd_c[k]      = {nmag_c[k], 30'd0} + 63'(n2_s2[N2_W-1:1]);
			lane_c[k].rem = REM_W'(dvd_c[k][62:31]);
			lane_c[k].dlo = dvd_c[k][30:0];
			lane_c[k].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			camx_s3  <= negx_s2 ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
			camy_s3  <= negy_s2 ? -$signed({1'b0, qy_c}) : $signed({1'b0, qy_c});
			range_s3 <= range_s2;
			veh_s3   <= veh_s2;
			n2_s3    <= n2_s2;
			bad_s3   <= (n2_s2 == '0);
			lane_s3  <= lane_c;
			for (int k = 0; k < NLANE; k++)
				neg_s3[k] <= num_s2[k][33];
		end
	end

	// s4: signed axis permutation and mount offset
	logic signed [CAM_W-1:0]  cam_c [3];
	logic signed [BODY_W-1:0] body_c [3];
	logic [1:0]               code_c;
	side_t                    side_s4;
	div_lane_t [NLANE-1:0]    lane_s4;
	logic                     v_s4;

	always_comb begin
		cam_c[0] = camx_s3;
		cam_c[1] = camy_s3;
		cam_c[2] = $signed({15'd0, range_s3});
		code_c   = '0;
		for (int i = 0; i < 3; i++) begin
			body_c[i] = BODY_W'($signed(cfg.off[i]));
			for (int j = 0; j < 3; j++) begin
				code_c = cfg.axis[2*(3*i+j) +: 2];
				case (code_c)
					AX_PLUS:  body_c[i] = body_c[i] + BODY_W'(cam_c[j]);
					AX_MINUS: body_c[i] = body_c[i] - BODY_W'(cam_c[j]);
					default:  body_c[i] = body_c[i];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				side_s4.body[i] <= body_c[i];
			side_s4.veh <= veh_s3;
			side_s4.n2  <= n2_s3;
			side_s4.neg <= neg_s3;
			side_s4.bad <= bad_s3;
			lane_s4     <= lane_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_v = v_s4;
	assign lanes = lane_s4;
	assign side  = side_s4;

endmodule

// ===== design/p2w_div.sv =====
module p2w_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_v,
	input  p2w_pkg::div_lane_t [p2w_pkg::NLANE-1:0] lanes_in,
	input  p2w_pkg::side_t                          side_in,
	output logic                                    out_v,
	output logic [p2w_pkg::NLANE-1:0][p2w_pkg::QW-1:0] quo,
	output p2w_pkg::side_t                          side_out
);
	import p2w_pkg::*;

	// one restoring quotient bit per stage, nine lanes side by side
	function automatic div_lane_t div_step(div_lane_t a, logic [N2_W-1:0] d);
		logic [REM_W:0] t;
		div_lane_t      r;
		t     = {a.rem, a.dlo[QW-1]};
		r.dlo = {a.dlo[QW-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem = REM_W'(t - {1'b0, d});
			r.quo = {a.quo[QW-2:0], 1'b1};
		end else begin
			r.rem = t[REM_W-1:0];
			r.quo = {a.quo[QW-2:0], 1'b0};
		end
		return r;
	endfunction

	div_lane_t [NLANE-1:0] lane_s [1:DIV_STEPS];
	side_t                 side_s [1:DIV_STEPS];
	logic                  v_s    [1:DIV_STEPS];

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		div_lane_t [NLANE-1:0] lane_p;
		side_t                 side_p;
		logic                  v_p;

		if (k == 1) begin : g_first
			assign lane_p = lanes_in;
			assign side_p = side_in;
			assign v_p    = in_v;
		end else begin : g_rest
			assign lane_p = lane_s[k-1];
			assign side_p = side_s[k-1];
			assign v_p    = v_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_p;
				for (int l = 0; l < NLANE; l++)
					lane_s[k][l] <= div_step(lane_p[l], side_p.n2);
			end
		end
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_quo
		assign quo[l] = lane_s[DIV_STEPS][l].quo;
	end

	assign out_v    = v_s[DIV_STEPS];
	assign side_out = side_s[DIV_STEPS];

endmodule

// ===== design/p2w_back.sv =====
module p2w_back (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  logic                                       in_v,
	input  logic [p2w_pkg::NLANE-1:0][p2w_pkg::QW-1:0] quo,
	input  p2w_pkg::side_t                             side,
	output logic                                       out_v,
	output p2w_pkg::res_t                              res
);
	import p2w_pkg::*;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [52:0] SAT_HI  = 53'sh0_7FFF_FFFF;
	localparam logic signed [52:0] SAT_LO  = -53'sh0_8000_0000;

	// s1: rotation entries, split products
	logic signed [31:0] rot_c [3][3];
	logic signed [23:0] bh_c [3];
	logic signed [24:0] bl_c [3];
	logic signed [55:0] ph_s1 [3][3];
	logic signed [56:0] pl_s1 [3][3];
	logic [2:0][31:0]   veh_s1;
	logic               bad_s1;
	logic               v_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bh_c[i] = $signed(side.body[i][BODY_W-1:24]);
			bl_c[i] = $signed({1'b0, side.body[i][23:0]});
			for (int j = 0; j < 3; j++) begin
				if (side.bad)
					rot_c[i][j] = (i == j) ? ONE_Q30 : '0;
				else if (side.neg[3*i+j])
					rot_c[i][j] = -$signed({1'b0, quo[3*i+j]});
				else
					rot_c[i][j] = $signed({1'b0, quo[3*i+j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					ph_s1[i][j] <= bh_c[j] * rot_c[i][j];
					pl_s1[i][j] <= bl_c[j] * rot_c[i][j];
				end
			veh_s1 <= side.veh;
			bad_s1 <= side.bad;
		end
	end

	// s2: row sums of partial products
	logic signed [57:0] sh_s2 [3];
	logic signed [58:0] sl_s2 [3];
	logic [2:0][31:0]   veh_s2;
	logic               bad_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sh_s2[i] <= 58'(ph_s1[i][0]) + 58'(ph_s1[i][1]) + 58'(ph_s1[i][2]);
				sl_s2[i] <= 59'(pl_s1[i][0]) + 59'(pl_s1[i][1]) + 59'(pl_s1[i][2]);
			end
			veh_s2 <= veh_s1;
			bad_s2 <= bad_s1;
		end
	end

	// s3: full sum with half-up rounding bias
	logic signed [81:0] t_s3 [3];
	logic [2:0][31:0]   veh_s3;
	logic               bad_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				t_s3[i] <= (82'(sh_s2[i]) <<< 24) + 82'(sl_s2[i]) + (82'sd1 <<< 29);
			veh_s3 <= veh_s2;
			bad_s3 <= bad_s2;
		end
	end

	// s4: translate and saturate
	logic signed [51:0] tq_c [3];
	logic signed [52:0] r_c [3];
	logic [2:0][31:0]   w_c;
	logic [2:0]         clip_c;
	res_t               res_s4;
	logic               v_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tq_c[i] = t_s3[i][81:30];
			r_c[i]  = 53'(tq_c[i]) + 53'($signed(veh_s3[i]));
			if (r_c[i] > SAT_HI) begin
				w_c[i]    = 32'h7FFF_FFFF;
				clip_c[i] = 1'b1;
			end else if (r_c[i] < SAT_LO) begin
				w_c[i]    = 32'h8000_0000;
				clip_c[i] = 1'b1;
			end else begin
				w_c[i]    = r_c[i][31:0];
				clip_c[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.world   <= w_c;
			res_s4.clipped <= |clip_c;
			res_s4.bad     <= bad_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_v = v_s4;
	assign res   = res_s4;

endmodule

// ===== bench/tb_pixel_to_world_projection.sv =====
module tb_pixel_to_world_projection;
	import p2w_pkg::*;

	typedef struct {
		logic [15:0]        u;
		logic [15:0]        v;
		logic [31:0]        rng;
		logic signed [15:0] qw;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} target_t;

	typedef struct {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
		logic               clip;
		logic               bad;
	} world_t;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 60;
	localparam logic signed [127:0] S_MAX = 128'sd2147483647;
	localparam logic signed [127:0] S_MIN = -128'sd2147483648;

	logic clk = 1'b0;
	logic arst_n;

	p2w_in_if  pix_if ();
	p2w_out_if res_if ();
	p2w_cfg_if cfg_if ();

	pixel_to_world_projection u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if.sink),
		.res    (res_if.source),
		.cfg    (cfg_if.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow registers
	logic [23:0]        sh_ifx, sh_ify;
	logic [15:0]        sh_cx, sh_cy;
	logic [17:0]        sh_axis;
	logic signed [31:0] sh_off [3];

	world_t pending_world [$];
	int     errors = 0;
	int     cycles = 0;
	int     hold_req = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic logic signed [127:0] ray_scale(logic signed [127:0] s, logic [31:0] r);
		logic signed [127:0] p, m, q, rr;
		rr = r;
		p = s * rr;
		m = (p < 0) ? -p : p;
		q = (m + (128'sd1 <<< 27)) >>> 28;
		return (p < 0) ? -q : q;
	endfunction

	function automatic logic signed [127:0] q30_ratio(longint n, longint d);
		longint m, q;
		m = (n < 0) ? -n : n;
		q = ((m <<< 30) + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic world_t project(target_t t);
		logic signed [127:0] cam [3];
		logic signed [127:0] body [3];
		logic signed [127:0] rot [3][3];
		logic signed [127:0] veh [3];
		logic signed [127:0] du, dv, ifx, ify, acc, r;
		logic signed [31:0]  wr [3];
		longint w, x, y, z, n2;
		logic [1:0] code;
		world_t o;
		w = t.qw; x = t.qx; y = t.qy; z = t.qz;
		n2 = w * w + x * x + y * y + z * z;
		du = t.u; du = du - sh_cx;
		dv = t.v; dv = dv - sh_cy;
		ifx = sh_ifx; ify = sh_ify;
		cam[0] = ray_scale(du * ifx, t.rng);
		cam[1] = ray_scale(dv * ify, t.rng);
		cam[2] = ray_scale(128'sd1 <<< 28, t.rng);
		for (int i = 0; i < 3; i++) begin
			body[i] = sh_off[i];
			for (int j = 0; j < 3; j++) begin
				code = sh_axis[2 * (3 * i + j) +: 2];
				if (code == AX_PLUS)
					body[i] = body[i] + cam[j];
				else if (code == AX_MINUS)
					body[i] = body[i] - cam[j];
			end
		end
		if (n2 == 0) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					rot[i][j] = (i == j) ? (128'sd1 <<< 30) : 128'sd0;
		end else begin
			rot[0][0] = q30_ratio(w * w + x * x - y * y - z * z, n2);
			rot[0][1] = q30_ratio(2 * (x * y - w * z), n2);
			rot[0][2] = q30_ratio(2 * (x * z + w * y), n2);
			rot[1][0] = q30_ratio(2 * (x * y + w * z), n2);
			rot[1][1] = q30_ratio(w * w - x * x + y * y - z * z, n2);
			rot[1][2] = q30_ratio(2 * (y * z - w * x), n2);
			rot[2][0] = q30_ratio(2 * (x * z - w * y), n2);
			rot[2][1] = q30_ratio(2 * (y * z + w * x), n2);
			rot[2][2] = q30_ratio(w * w - x * x - y * y + z * z, n2);
		end
		veh[0] = t.px; veh[1] = t.py; veh[2] = t.pz;
		o.clip = 1'b0;
		o.bad = (n2 == 0);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc = acc + body[j] * rot[i][j];
			r = ((acc + (128'sd1 <<< 29)) >>> 30) + veh[i];
			if (r > S_MAX) begin
				r = S_MAX;
				o.clip = 1'b1;
			end else if (r < S_MIN) begin
				r = S_MIN;
				o.clip = 1'b1;
			end
			wr[i] = r[31:0];
		end
		o.wx = wr[0]; o.wy = wr[1]; o.wz = wr[2];
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		world_t e;
		if (res_if.valid && res_if.ready) begin
			if (pending_world.size() == 0) begin
				report("unexpected word", res_if.world_x, 0);
			end else begin
				e = pending_world.pop_front();
				if (res_if.world_x !== e.wx) report("world_x", res_if.world_x, e.wx);
				if (res_if.world_y !== e.wy) report("world_y", res_if.world_y, e.wy);
				if (res_if.world_z !== e.wz) report("world_z", res_if.world_z, e.wz);
				if (res_if.clipped !== e.clip) report("clipped", res_if.clipped, e.clip);
				if (res_if.bad_attitude !== e.bad)
					report("bad_attitude", res_if.bad_attitude, e.bad);
			end
		end
	end

	// receiver stall pattern
	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				res_if.ready <= 1'b0;
				hold_req--;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 64);
				end
				left--;
				case (mode)
					0: res_if.ready <= 1'b1;
					1: res_if.ready <= ($urandom_range(0, 3) != 0);
					2: res_if.ready <= ($urandom_range(0, 3) == 0);
					default: res_if.ready <= cycles[0];
				endcase
			end
		end
	end

	task automatic put_target(target_t t, bit typed, world_t want);
		pix_if.valid      <= 1'b1;
		pix_if.pixel_u    <= t.u;
		pix_if.pixel_v    <= t.v;
		pix_if.range_dist <= t.rng;
		pix_if.quat_w     <= t.qw;
		pix_if.quat_x     <= t.qx;
		pix_if.quat_y     <= t.qy;
		pix_if.quat_z     <= t.qz;
		pix_if.vehicle_x  <= t.px;
		pix_if.vehicle_y  <= t.py;
		pix_if.vehicle_z  <= t.pz;
		do @(posedge clk); while (!pix_if.ready);
		pending_world.push_back(typed ? want : project(t));
	endtask

	task automatic pause(int n);
		pix_if.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		pix_if.valid <= 1'b0;
		do @(posedge clk); while (pending_world.size() != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_regs(logic [23:0] fx, logic [23:0] fy, logic [15:0] cx,
			logic [15:0] cy, logic [17:0] ax, logic [31:0] ox, logic [31:0] oy,
			logic [31:0] oz);
		logic [31:0] vals [8];
		vals = '{fx, fy, cx, cy, ax, ox, oy, oz};
		for (int i = 0; i < 8; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= i[IDX_W-1:0];
			cfg_if.data  <= vals[i];
			do @(posedge clk); while (!cfg_if.ready);
			case (i[IDX_W-1:0])
				REG_INV_FX: sh_ifx = vals[i][23:0];
				REG_INV_FY: sh_ify = vals[i][23:0];
				REG_CX:     sh_cx = vals[i][15:0];
				REG_CY:     sh_cy = vals[i][15:0];
				REG_AXIS:   sh_axis = vals[i][17:0];
				REG_OFF_X:  sh_off[0] = vals[i];
				REG_OFF_Y:  sh_off[1] = vals[i];
				default:    sh_off[2] = vals[i];
			endcase
		end
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic target_t mk(logic [15:0] u, logic [15:0] v, logic [31:0] rng,
			logic [15:0] qw, logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		target_t t;
		t.u = u; t.v = v; t.rng = rng;
		t.qw = qw; t.qx = qx; t.qy = qy; t.qz = qz;
		t.px = px; t.py = py; t.pz = pz;
		return t;
	endfunction

	function automatic world_t wv(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic c, logic b);
		world_t o;
		o.wx = x; o.wy = y; o.wz = z; o.clip = c; o.bad = b;
		return o;
	endfunction

	function automatic target_t rand_target();
		target_t t;
		int kind;
		kind = $urandom_range(0, 9);
		t.u = 16'($urandom); t.v = 16'($urandom); t.rng = $urandom;
		t.qw = 16'($urandom); t.qx = 16'($urandom);
		t.qy = 16'($urandom); t.qz = 16'($urandom);
		t.px = $urandom; t.py = $urandom; t.pz = $urandom;
		if (kind >= 2) begin
			t.u = 16'(sh_cx + $urandom_range(0, 8000) - 4000);
			t.v = 16'(sh_cy + $urandom_range(0, 8000) - 4000);
			t.rng = $urandom_range(0, 32'h00FF_FFFF);
			t.qw = 16'($urandom_range(0, 32767) - 16384);
			t.qx = 16'($urandom_range(0, 32767) - 16384);
			t.qy = 16'($urandom_range(0, 32767) - 16384);
			t.qz = 16'($urandom_range(0, 32767) - 16384);
			t.px = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
			t.py = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
			t.pz = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
		end
		if (kind == 1 || kind == 9) begin
			t.qw = 0; t.qx = 0; t.qy = 0; t.qz = 0;
		end
		return t;
	endfunction

	function automatic logic [17:0] rand_axis();
		logic [17:0] a;
		int p [3];
		int k;
		if ($urandom_range(0, 3) == 0)
			return 18'($urandom);
		p = '{0, 1, 2};
		k = $urandom_range(0, 2);
		p[0] = k; p[k] = 0;
		if ($urandom_range(0, 1)) begin
			k = p[1]; p[1] = p[2]; p[2] = k;
		end
		a = '0;
		for (int r = 0; r < 3; r++)
			a[2 * (3 * r + p[r]) +: 2] = $urandom_range(0, 1) ? AX_PLUS : AX_MINUS;
		return a;
	endfunction

	target_t dir_tab [$];
	bit      dir_typed [$];
	world_t  dir_want [$];

	initial begin
		int burst;
		bit held;
		world_t none;
		held = 1'b0;
		none = wv(0, 0, 0, 0, 0);
		arst_n = 1'b0;
		pix_if.valid <= 1'b0;
		pix_if.pixel_u <= '0; pix_if.pixel_v <= '0; pix_if.range_dist <= '0;
		pix_if.quat_w <= '0; pix_if.quat_x <= '0; pix_if.quat_y <= '0; pix_if.quat_z <= '0;
		pix_if.vehicle_x <= '0; pix_if.vehicle_y <= '0; pix_if.vehicle_z <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data  <= '0;
		sh_ifx = RST_INV_FOCAL; sh_ify = RST_INV_FOCAL;
		sh_cx = RST_CENTER_X; sh_cy = RST_CENTER_Y; sh_axis = RST_AXIS_MAP;
		sh_off[0] = 0; sh_off[1] = 0; sh_off[2] = 1311;

		// pixel at principal point, no range: only the mount offset remains
		dir_tab.push_back(mk(6792, 3848, 0, 16384, 0, 0, 0, 0, 0, 0));
		dir_typed.push_back(1); dir_want.push_back(wv(0, 0, 1311, 0, 0));
		// zero quaternion, identity, saturation high
		dir_tab.push_back(mk(6792, 3848, 0, 0, 0, 0, 0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		dir_typed.push_back(1);
		dir_want.push_back(wv(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1));
		dir_tab.push_back(mk(6792, 3848, 0, 0, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		dir_typed.push_back(1);
		dir_want.push_back(wv(32'h8000_0000, 32'h8000_0000, 32'h8000_051F, 0, 1));
		dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_typed.push_back(1); dir_want.push_back(wv(0, 0, 1311, 0, 1));
		dir_tab.push_back(mk(0, 0, 32'hFFFF_FFFF, 16'h7FFF, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		dir_tab.push_back(mk(16'hFFFF, 0, 32'h0001_0000, 0, 0, 0, 16'h7FFF, 0, 0, 0));
		dir_tab.push_back(mk(0, 16'hFFFF, 32'h0001_0000, 0, 16'h4000, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(7000, 4000, 32'h000A_0000, 0, 0, 16'hC000, 0, 5, -5, 0));
		dir_tab.push_back(mk(6000, 3000, 32'h0005_8000, 16'h2D41, 16'h2D41, 0, 0,
			32'h0010_0000, 32'hFFF0_0000, 32'h0100_0000));
		dir_tab.push_back(mk(1, 1, 1, 0, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(mk(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		dir_tab.push_back(mk(6792, 3848, 32'h8000_0000, 16'h8000, 0, 0, 0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		while (dir_typed.size() < dir_tab.size()) begin
			dir_typed.push_back(0);
			dir_want.push_back(none);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			put_target(dir_tab[i], dir_typed[i], dir_want[i]);
			if ($urandom_range(0, 2) == 0)
				pause($urandom_range(1, 3));
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_regs(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				1: write_regs(0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				// code two entries act as zero
				2: write_regs(RST_INV_FOCAL, RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y,
					18'h2AAAA ^ 18'h00111, 0, 0, 1311);
				7: write_regs(RST_INV_FOCAL, RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y,
					RST_AXIS_MAP, 0, 0, 1311);
				default: write_regs(24'($urandom_range(20000, 80000)), 24'($urandom),
					16'($urandom), 16'($urandom), rand_axis(),
					$signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000,
					$urandom, $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
			endcase
			for (int n = 0; n < 50; ) begin
				burst = $urandom_range(1, 20);
				if (ph == 4 && n >= 10 && !held) begin
					hold_req = 300;
					held = 1'b1;
				end
				for (int b = 0; b < burst && n < 50; b++, n++)
					put_target(rand_target(), 0, none);
				if ($urandom_range(0, 3) != 0)
					pause($urandom_range(1, 8));
			end
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/p2w_pkg.sv
design/p2w_if.sv
design/p2w_front.sv
design/p2w_div.sv
design/p2w_back.sv
design/pixel_to_world_projection.sv
bench/tb_pixel_to_world_projection.sv
